>>> rtl/ukal_pkg.sv
// ----------------------------------------------------------------------------
// ukal_pkg: shared constants and types of the unique-key list
// sizes of the list, operation codes and the per-cell control word
// ----------------------------------------------------------------------------
package ukal_pkg;

    localparam int DEPTH        = 16;
    localparam int KEY_BITS     = 64;
    localparam int PAYLOAD_BITS = 32;

    // widths fixed by the port list
    localparam int FUNC_W    = 3;
    localparam int POSN_W    = 5;
    localparam int KEY_IN_W  = 64;
    localparam int PAY_IN_W  = 32;
    localparam int FIDX_W    = 4;
    localparam int ECOUNT_W  = 5;

    // internal widths that follow from the depth
    localparam int IDX_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam int CMP_W    = (CNT_BITS > POSN_W) ? CNT_BITS : POSN_W;

    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_APPEND = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd4;

    // what one cell does at the next edge
    typedef struct packed {
        logic load;       // take the new key and payload
        logic take_prev;  // take the lower neighbour's entry (shift up)
        logic take_next;  // take the upper neighbour's entry (shift down)
    } t_cell_ctl;

endpackage

>>> rtl/ukal_cell.sv
// ----------------------------------------------------------------------------
// ukal_cell: one entry of the list
// holds a key and payload, compares its key, shifts with its neighbours
// ----------------------------------------------------------------------------
module ukal_cell (
    input  logic                             i_clk,
    input  ukal_pkg::t_cell_ctl              i_ctl,
    input  logic [ukal_pkg::KEY_BITS-1:0]     i_new_key,
    input  logic [ukal_pkg::PAYLOAD_BITS-1:0] i_new_pay,
    input  logic [ukal_pkg::KEY_BITS-1:0]     i_prev_key,
    input  logic [ukal_pkg::PAYLOAD_BITS-1:0] i_prev_pay,
    input  logic [ukal_pkg::KEY_BITS-1:0]     i_next_key,
    input  logic [ukal_pkg::PAYLOAD_BITS-1:0] i_next_pay,
    output logic [ukal_pkg::KEY_BITS-1:0]     o_key,
    output logic [ukal_pkg::PAYLOAD_BITS-1:0] o_pay,
    output logic                             o_match
);

    logic [ukal_pkg::KEY_BITS-1:0]     r_key;
    logic [ukal_pkg::PAYLOAD_BITS-1:0] r_pay;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_key <= i_new_key;
            r_pay <= i_new_pay;
        end else if (i_ctl.take_prev) begin
            r_key <= i_prev_key;
            r_pay <= i_prev_pay;
        end else if (i_ctl.take_next) begin
            r_key <= i_next_key;
            r_pay <= i_next_pay;
        end
    end

    assign o_key   = r_key;
    assign o_pay   = r_pay;
    assign o_match = (r_key == i_new_key);

endmodule

>>> rtl/ukal_ctrl.sv
// ----------------------------------------------------------------------------
// ukal_ctrl: list control
// decodes the operation, steers the cells, keeps the count, registers results
// ----------------------------------------------------------------------------
module ukal_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  logic [ukal_pkg::FUNC_W-1:0]         i_func,
    input  logic [ukal_pkg::POSN_W-1:0]         i_position,
    input  logic [ukal_pkg::DEPTH-1:0]          i_match,
    input  logic [ukal_pkg::KEY_BITS-1:0]       i_key [ukal_pkg::DEPTH],
    input  logic [ukal_pkg::PAYLOAD_BITS-1:0]   i_pay [ukal_pkg::DEPTH],
    output ukal_pkg::t_cell_ctl                 o_ctl [ukal_pkg::DEPTH],
    output logic                                o_done,
    output logic                                o_ok,
    output logic [ukal_pkg::FIDX_W-1:0]         o_found_index,
    output logic [ukal_pkg::KEY_IN_W-1:0]       o_key_out,
    output logic [ukal_pkg::PAY_IN_W-1:0]       o_payload_out,
    output logic [ukal_pkg::ECOUNT_W-1:0]       o_entry_count,
    output logic                                o_is_full,
    output logic                                o_is_empty
);

    logic [ukal_pkg::CNT_BITS-1:0]     r_count, n_count;
    logic                              r_done;
    logic                              r_ok, n_ok;
    logic [ukal_pkg::FIDX_W-1:0]       r_fidx, n_fidx;
    logic [ukal_pkg::KEY_IN_W-1:0]     r_kout, n_kout;
    logic [ukal_pkg::PAY_IN_W-1:0]     r_pout, n_pout;

    logic [ukal_pkg::CMP_W-1:0]        w_pos;
    logic [ukal_pkg::CMP_W-1:0]        w_cnt;
    logic                              w_hit;
    logic [ukal_pkg::IDX_BITS-1:0]     w_hit_idx;
    logic                              w_full;
    logic                              w_pos_in;    // position below count
    logic                              w_add_ok;
    logic [ukal_pkg::KEY_BITS-1:0]     w_rd_key;
    logic [ukal_pkg::PAYLOAD_BITS-1:0] w_rd_pay;

    assign w_pos    = ukal_pkg::CMP_W'(i_position);
    assign w_cnt    = ukal_pkg::CMP_W'(r_count);
    assign w_full   = (r_count == ukal_pkg::CNT_BITS'(ukal_pkg::DEPTH));
    assign w_pos_in = (w_pos < w_cnt);
    assign w_add_ok = !w_full && !w_hit;

    // live matches and first hit
    always_comb begin
        w_hit     = 1'b0;
        w_hit_idx = '0;
        for (int i = ukal_pkg::DEPTH - 1; i >= 0; i--) begin
            if (i_match[i] && (ukal_pkg::CNT_BITS'(i) < r_count)) begin
                w_hit     = 1'b1;
                w_hit_idx = ukal_pkg::IDX_BITS'(i);
            end
        end
    end

    // read select
    always_comb begin
        w_rd_key = '0;
        w_rd_pay = '0;
        for (int i = 0; i < ukal_pkg::DEPTH; i++) begin
            if (ukal_pkg::CMP_W'(i) == w_pos) begin
                w_rd_key = i_key[i];
                w_rd_pay = i_pay[i];
            end
        end
    end

    // cell steering and results
    always_comb begin
        n_count = r_count;
        n_ok    = 1'b0;
        n_fidx  = '0;
        n_kout  = '0;
        n_pout  = '0;
        for (int i = 0; i < ukal_pkg::DEPTH; i++) begin
            o_ctl[i] = '0;
        end
        case (i_func)
            ukal_pkg::FUNC_SEARCH: begin
                n_ok   = w_hit;
                n_fidx = w_hit ? ukal_pkg::FIDX_W'(w_hit_idx) : '0;
            end
            ukal_pkg::FUNC_APPEND: begin
                if (w_add_ok) begin
                    n_ok    = 1'b1;
                    n_count = r_count + ukal_pkg::CNT_BITS'(1);
                    for (int i = 0; i < ukal_pkg::DEPTH; i++) begin
                        o_ctl[i].load = i_accept && (ukal_pkg::CNT_BITS'(i) == r_count);
                    end
                end
            end
            ukal_pkg::FUNC_INSERT: begin
                if (w_add_ok && (w_pos <= w_cnt)) begin
                    n_ok    = 1'b1;
                    n_count = r_count + ukal_pkg::CNT_BITS'(1);
                    for (int i = 0; i < ukal_pkg::DEPTH; i++) begin
                        o_ctl[i].load      = i_accept && (ukal_pkg::CMP_W'(i) == w_pos);
                        o_ctl[i].take_prev = i_accept && (ukal_pkg::CMP_W'(i) > w_pos)
                                             && (ukal_pkg::CMP_W'(i) <= w_cnt);
                    end
                end
            end
            ukal_pkg::FUNC_REMOVE: begin
                if (w_pos_in) begin
                    n_ok    = 1'b1;
                    n_count = r_count - ukal_pkg::CNT_BITS'(1);
                    for (int i = 0; i < ukal_pkg::DEPTH; i++) begin
                        o_ctl[i].take_next = i_accept && (ukal_pkg::CMP_W'(i) >= w_pos)
                                             && (ukal_pkg::CMP_W'(i + 1) < w_cnt);
                    end
                end
            end
            ukal_pkg::FUNC_READ: begin
                if (w_pos_in) begin
                    n_ok   = 1'b1;
                    n_kout = ukal_pkg::KEY_IN_W'(w_rd_key);
                    n_pout = ukal_pkg::PAY_IN_W'(w_rd_pay);
                end
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= i_accept;
            if (i_accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_ok   <= n_ok;
            r_fidx <= n_fidx;
            r_kout <= n_kout;
            r_pout <= n_pout;
        end
    end

    assign o_done        = r_done;
    assign o_ok          = r_ok;
    assign o_found_index = r_fidx;
    assign o_key_out     = r_kout;
    assign o_payload_out = r_pout;
    assign o_entry_count = ukal_pkg::ECOUNT_W'(r_count);
    assign o_is_full     = (r_count == ukal_pkg::CNT_BITS'(ukal_pkg::DEPTH));
    assign o_is_empty    = (r_count == '0);

endmodule

>>> rtl/unique_key_array_list_unit.sv
// ----------------------------------------------------------------------------
// unique_key_array_list_unit: ordered list of entries with unique keys
// a row of entry cells with one controller; one operation per clock
// ----------------------------------------------------------------------------
// An item (operation) is taken at any rising edge where start is high; busy
// is always low, so a new item may follow in every cycle. Its result shows
// on the o_ ports for exactly one cycle, marked by o_done, in the cycle right
// after the item was taken, and the receiver cannot hold it off. The work
// is done by the cells: all of them compare their key against i_key_in at
// once and shift with their neighbours at the same edge, so search, append,
// insert, remove and read each complete at the edge that takes them.
// o_entry_count, o_is_full and o_is_empty give the state after the
// operation. The list is empty after reset; entry contents are not
// cleared, which no sequence of operations can observe.
// ----------------------------------------------------------------------------
module unique_key_array_list_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [ukal_pkg::FUNC_W-1:0]       i_func,
    input  logic [ukal_pkg::POSN_W-1:0]       i_position,
    input  logic [ukal_pkg::KEY_IN_W-1:0]     i_key_in,
    input  logic [ukal_pkg::PAY_IN_W-1:0]     i_payload_in,
    output logic                              o_done,
    output logic                              o_ok,
    output logic [ukal_pkg::FIDX_W-1:0]       o_found_index,
    output logic [ukal_pkg::KEY_IN_W-1:0]     o_key_out,
    output logic [ukal_pkg::PAY_IN_W-1:0]     o_payload_out,
    output logic [ukal_pkg::ECOUNT_W-1:0]     o_entry_count,
    output logic                              o_is_full,
    output logic                              o_is_empty
);

    // every item completes at the edge that takes it, so the unit is never busy
    assign busy = 1'b0;

    logic                              w_accept;
    logic [ukal_pkg::KEY_BITS-1:0]     w_new_key;
    logic [ukal_pkg::PAYLOAD_BITS-1:0] w_new_pay;
    logic [ukal_pkg::KEY_BITS-1:0]     w_key   [ukal_pkg::DEPTH];
    logic [ukal_pkg::PAYLOAD_BITS-1:0] w_pay   [ukal_pkg::DEPTH];
    logic [ukal_pkg::DEPTH-1:0]        w_match;
    ukal_pkg::t_cell_ctl               w_ctl   [ukal_pkg::DEPTH];

    assign w_accept  = start && !busy;
    // key and payload are stored at the full port width
    assign w_new_key = ukal_pkg::KEY_BITS'(i_key_in);
    assign w_new_pay = ukal_pkg::PAYLOAD_BITS'(i_payload_in);

    // the row of cells; each end ties its missing neighbour to itself,
    // which the controller never selects
    for (genvar g = 0; g < ukal_pkg::DEPTH; g++) begin : g_cell
        logic [ukal_pkg::KEY_BITS-1:0]     w_pk, w_nk;
        logic [ukal_pkg::PAYLOAD_BITS-1:0] w_pp, w_np;

        if (g == 0) begin : g_lo
            assign w_pk = w_key[g];
            assign w_pp = w_pay[g];
        end else begin : g_mid_lo
            assign w_pk = w_key[g-1];
            assign w_pp = w_pay[g-1];
        end

        if (g == ukal_pkg::DEPTH - 1) begin : g_hi
            assign w_nk = w_key[g];
            assign w_np = w_pay[g];
        end else begin : g_mid_hi
            assign w_nk = w_key[g+1];
            assign w_np = w_pay[g+1];
        end

        ukal_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl[g]),
            .i_new_key  (w_new_key),
            .i_new_pay  (w_new_pay),
            .i_prev_key (w_pk),
            .i_prev_pay (w_pp),
            .i_next_key (w_nk),
            .i_next_pay (w_np),
            .o_key      (w_key[g]),
            .o_pay      (w_pay[g]),
            .o_match    (w_match[g])
        );
    end

    // decode, count, result register
    ukal_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_func        (i_func),
        .i_position    (i_position),
        .i_match       (w_match),
        .i_key         (w_key),
        .i_pay         (w_pay),
        .o_ctl         (w_ctl),
        .o_done        (o_done),
        .o_ok          (o_ok),
        .o_found_index (o_found_index),
        .o_key_out     (o_key_out),
        .o_payload_out (o_payload_out),
        .o_entry_count (o_entry_count),
        .o_is_full     (o_is_full),
        .o_is_empty    (o_is_empty)
    );

endmodule

>>> rtl/ukal_checker.sv
// ----------------------------------------------------------------------------
// ukal_checker: port-level checks of the unique-key list
// result timing, status flags and zeroed fields on rejection
// ----------------------------------------------------------------------------
module ukal_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          o_done,
    input  logic                          o_ok,
    input  logic [ukal_pkg::FIDX_W-1:0]   o_found_index,
    input  logic [ukal_pkg::KEY_IN_W-1:0] o_key_out,
    input  logic [ukal_pkg::PAY_IN_W-1:0] o_payload_out,
    input  logic [ukal_pkg::ECOUNT_W-1:0] o_entry_count,
    input  logic                          o_is_full,
    input  logic                          o_is_empty
);

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_done)
        else $error("item taken without a result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> !o_done)
        else $error("result without an item");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_is_empty == (o_entry_count == '0)))
        else $error("empty flag disagrees with count");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_is_full ==
            (o_entry_count == ukal_pkg::ECOUNT_W'(ukal_pkg::DEPTH))))
        else $error("full flag disagrees with count");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_ok) |->
            (o_found_index == '0 && o_key_out == '0 && o_payload_out == '0))
        else $error("rejected item carries data");

endmodule

bind unique_key_array_list_unit ukal_checker u_ukal_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_done        (o_done),
    .o_ok          (o_ok),
    .o_found_index (o_found_index),
    .o_key_out     (o_key_out),
    .o_payload_out (o_payload_out),
    .o_entry_count (o_entry_count),
    .o_is_full     (o_is_full),
    .o_is_empty    (o_is_empty)
);

>>> sim/unique_key_array_list_unit_tb.sv
// ----------------------------------------------------------------------------
// unique_key_array_list_unit_tb: self-checking bench for the unique-key list
// drives search, append, insert, remove and read items through the
// start/busy handshake, keeps a shadow copy of the list to predict each
// reply and compares every o_done strobe with the oldest predicted reply
// ----------------------------------------------------------------------------
import ukal_pkg::*;

// one reply as it shows on the o_ ports
typedef struct packed {
    logic                ok;
    logic [FIDX_W-1:0]   found_index;
    logic [KEY_IN_W-1:0] key_out;
    logic [PAY_IN_W-1:0] payload_out;
    logic [ECOUNT_W-1:0] entry_count;
    logic                is_full;
    logic                is_empty;
} list_reply_t;

// shadow list: follows every accepted item and queues the reply it must give
class entry_list_tracker;
    logic [KEY_BITS-1:0]     keys [DEPTH];
    logic [PAYLOAD_BITS-1:0] payloads [DEPTH];
    int                      count;
    list_reply_t             awaited_replies [$];
    int                      mismatches;

    function new();
        count      = 0;
        mismatches = 0;
    endfunction

    function int find_key(logic [KEY_BITS-1:0] key);
        for (int i = 0; i < count; i++)
            if (keys[i] == key)
                return i;
        return -1;
    endfunction

    function void note_op(logic [FUNC_W-1:0] func, logic [POSN_W-1:0] posn,
                          logic [KEY_IN_W-1:0] key_in, logic [PAY_IN_W-1:0] pay_in);
        list_reply_t             r;
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] pay;
        int                      hit;
        int                      p;
        r   = '0;
        key = key_in[KEY_BITS-1:0];
        pay = pay_in[PAYLOAD_BITS-1:0];
        p   = int'(posn);
        hit = find_key(key);
        case (func)
            FUNC_SEARCH: begin
                if (hit >= 0) begin
                    r.ok          = 1'b1;
                    r.found_index = hit[FIDX_W-1:0];
                end
            end
            FUNC_APPEND: begin
                if (count < DEPTH && hit < 0) begin
                    keys[count]     = key;
                    payloads[count] = pay;
                    count++;
                    r.ok = 1'b1;
                end
            end
            FUNC_INSERT: begin
                if (count < DEPTH && p <= count && hit < 0) begin
                    for (int i = count; i > p; i--) begin
                        keys[i]     = keys[i-1];
                        payloads[i] = payloads[i-1];
                    end
                    keys[p]     = key;
                    payloads[p] = pay;
                    count++;
                    r.ok = 1'b1;
                end
            end
            FUNC_REMOVE: begin
                if (p < count) begin
                    for (int i = p; i + 1 < count; i++) begin
                        keys[i]     = keys[i+1];
                        payloads[i] = payloads[i+1];
                    end
                    count--;
                    r.ok = 1'b1;
                end
            end
            FUNC_READ: begin
                if (p < count) begin
                    r.ok          = 1'b1;
                    r.key_out     = keys[p];
                    r.payload_out = payloads[p];
                end
            end
            default: ;
        endcase
        r.entry_count = count[ECOUNT_W-1:0];
        r.is_full     = (count == DEPTH);
        r.is_empty    = (count == 0);
        awaited_replies.push_back(r);
    endfunction

    function void check_reply(list_reply_t got);
        list_reply_t want;
        if (awaited_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("reply with none awaited: ok %0b count %0d", got.ok, got.entry_count);
            return;
        end
        want = awaited_replies.pop_front();
        if (got.ok !== want.ok || got.found_index !== want.found_index ||
            got.key_out !== want.key_out || got.payload_out !== want.payload_out ||
            got.entry_count !== want.entry_count || got.is_full !== want.is_full ||
            got.is_empty !== want.is_empty) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"reply mismatch (exp/got): ok %0b/%0b idx %0d/%0d key %h/%h ",
                          "pay %h/%h count %0d/%0d full %0b/%0b empty %0b/%0b"},
                         want.ok, got.ok, want.found_index, got.found_index,
                         want.key_out, got.key_out, want.payload_out, got.payload_out,
                         want.entry_count, got.entry_count, want.is_full, got.is_full,
                         want.is_empty, got.is_empty);
        end
    endfunction
endclass

module unique_key_array_list_unit_tb;

    // operation codes the block leaves unused
    localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = FUNC_READ + FUNC_W'(1);
    localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = '1;

    // cycles with no item taken and no reply seen before the run is abandoned;
    // each reply follows in the cycle after its item is taken
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1020;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [FUNC_W-1:0]   i_func;
    logic [POSN_W-1:0]   i_position;
    logic [KEY_IN_W-1:0] i_key_in;
    logic [PAY_IN_W-1:0] i_payload_in;
    logic                o_done;
    logic                o_ok;
    logic [FIDX_W-1:0]   o_found_index;
    logic [KEY_IN_W-1:0] o_key_out;
    logic [PAY_IN_W-1:0] o_payload_out;
    logic [ECOUNT_W-1:0] o_entry_count;
    logic                o_is_full;
    logic                o_is_empty;

    entry_list_tracker tracker = new();
    int                quiet_cycles = 0;
    int                burst_left   = 0;   // items still to go with no gap
    logic              growing      = 1'b1; // bias towards filling the list

    unique_key_array_list_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_func        (i_func),
        .i_position    (i_position),
        .i_key_in      (i_key_in),
        .i_payload_in  (i_payload_in),
        .o_done        (o_done),
        .o_ok          (o_ok),
        .o_found_index (o_found_index),
        .o_key_out     (o_key_out),
        .o_payload_out (o_payload_out),
        .o_entry_count (o_entry_count),
        .o_is_full     (o_is_full),
        .o_is_empty    (o_is_empty)
    );

    always #5 i_clk = ~i_clk;

    // monitor: values are read at the edge before any update lands, so an
    // item taken at this edge is noted before the reply that follows it
    always @(posedge i_clk) begin
        logic took;
        took = 1'b0;
        if (i_rst_n === 1'b1) begin
            if (start === 1'b1 && busy === 1'b0) begin
                tracker.note_op(i_func, i_position, i_key_in, i_payload_in);
                took = 1'b1;
            end
            if (o_done !== 1'b0) begin
                tracker.check_reply('{o_ok, o_found_index, o_key_out, o_payload_out,
                                      o_entry_count, o_is_full, o_is_empty});
                took = 1'b1;
            end
        end
        // watchdog on cycles where nothing moves
        if (took)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // mostly short gaps, a few long ones, and bursts with none at all
    function automatic int pick_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
            burst_left = $urandom_range(20, 60);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // keys: often one already in the list, often from a small pool so that
    // duplicates and search hits are common, otherwise fully random
    function automatic logic [KEY_IN_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35 && tracker.count > 0)
            return tracker.keys[$urandom_range(0, tracker.count - 1)];
        if (r < 60)
            return ($urandom_range(0, 1) ? {KEY_IN_W{1'b1}} : {KEY_IN_W{1'b0}}) ^
                   KEY_IN_W'($urandom_range(0, 11));
        return {$urandom, $urandom};
    endfunction

    // positions: mostly within 0..count, sometimes anywhere in the field
    function automatic logic [POSN_W-1:0] pick_position();
        if ($urandom_range(0, 99) < 85)
            return POSN_W'($urandom_range(0, tracker.count));
        return POSN_W'($urandom_range(0, 31));
    endfunction

    // present one item, hold it until taken, then leave a random gap
    task automatic issue_op(input logic [FUNC_W-1:0] func, input logic [POSN_W-1:0] posn,
                            input logic [KEY_IN_W-1:0] key, input logic [PAY_IN_W-1:0] pay);
        int gap;
        start        <= 1'b1;
        i_func       <= func;
        i_position   <= posn;
        i_key_in     <= key;
        i_payload_in <= pay;
        do @(posedge i_clk); while (busy !== 1'b0);
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // sender holds off until every reply owed has come back
    task automatic drain_replies();
        start <= 1'b0;
        do @(posedge i_clk); while (tracker.awaited_replies.size() != 0);
    endtask

    initial begin
        logic [KEY_IN_W-1:0] last_key;
        logic [KEY_IN_W-1:0] fill_key;
        logic [FUNC_W-1:0]   func;
        int                  r;

        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_func       <= FUNC_SEARCH;
        i_position   <= '0;
        i_key_in     <= '0;
        i_payload_in <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: rejects on the empty list
        issue_op(FUNC_SEARCH, '0, '0, '0);                 // search miss
        issue_op(FUNC_READ, '1, '1, '1);                   // read far beyond count
        issue_op(FUNC_REMOVE, '0, '0, '0);                 // remove from empty list
        issue_op(FUNC_INSERT, 5'd1, 64'h1, 32'h1);         // insert beyond count
        // extreme keys and payloads, duplicates
        issue_op(FUNC_APPEND, '0, '1, '1);
        issue_op(FUNC_APPEND, '0, '1, 32'h1234_5678);      // duplicate append
        issue_op(FUNC_INSERT, '0, '0, '0);                 // insert at head
        issue_op(FUNC_INSERT, 5'd1, '0, 32'h5);            // duplicate insert
        issue_op(FUNC_SPARE_HI, '1, '1, '1);               // unused operation code
        // fill to capacity, alternating insert in the middle and append
        for (int i = 0; i < 14; i++) begin
            fill_key = {32'hA5A5_0000 | 32'(i), $urandom};
            if (i % 2 == 0)
                issue_op(FUNC_INSERT, POSN_W'((2 + i) / 2), fill_key, $urandom);
            else
                issue_op(FUNC_APPEND, '0, fill_key, $urandom);
            last_key = fill_key;
        end
        // full list: both ways of adding are turned away
        issue_op(FUNC_APPEND, '0, 64'h8000_0000_0000_0001, 32'h8000_0001);
        issue_op(FUNC_INSERT, '0, 64'h8000_0000_0000_0002, 32'h8000_0002);
        issue_op(FUNC_SEARCH, '0, last_key, '0);           // hit at the top index
        issue_op(FUNC_READ, 5'd15, '0, '0);
        issue_op(FUNC_REMOVE, 5'd15, '0, '0);

        // random: phases that grow the list to full and shrink it to empty
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 200 == 0)
                drain_replies();
            if (tracker.count == DEPTH)
                growing = 1'b0;
            else if (tracker.count == 0)
                growing = 1'b1;
            else if ($urandom_range(0, 99) < 2)
                growing = ~growing;
            r = $urandom_range(0, 99);
            if (r < 15)
                func = FUNC_SEARCH;
            else if (r < (growing ? 45 : 23))
                func = FUNC_APPEND;
            else if (r < (growing ? 75 : 31))
                func = FUNC_INSERT;
            else if (r < (growing ? 85 : 81))
                func = FUNC_REMOVE;
            else if (r < 97)
                func = FUNC_READ;
            else
                func = FUNC_SPARE_LO + FUNC_W'($urandom_range(0, FUNC_SPARE_HI - FUNC_SPARE_LO));
            issue_op(func, pick_position(), pick_key(), $urandom);
        end

        // let the last replies come in, then wait on for stray replies
        start <= 1'b0;
        do @(posedge i_clk); while (tracker.awaited_replies.size() != 0);
        repeat (4) @(posedge i_clk);
        if (tracker.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
